### rtl/pis_pkg.sv
// Shared constants and record type for the prefix insertion sorter.
// No dependencies; used by pis_ram users and the top level.
package pis_pkg;

  localparam int MAX_RECORDS  = 256;
  localparam int RESULT_LIMIT = 64;
  localparam int CAPACITY     = (MAX_RECORDS < RESULT_LIMIT) ? MAX_RECORDS : RESULT_LIMIT;

  localparam int KEY_W = 16;
  localparam int TAG_W = 8;
  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [AW-1:0]    addr_t;
  typedef logic [CW-1:0]    cnt_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

### rtl/pis_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; read data holds while the read enable is low.
module pis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/prefix_insertion_sorter.sv
// Prefix insertion sorter top level: load, sort sequencer and emission.
// Depends on pis_pkg and pis_ram.
//
// Records load one beat per cycle into a 64-entry record RAM until a beat
// marked last arrives; beats beyond 64 are dropped and raise overflow on every
// result of that set. The first floor(n/2) records are then insertion-sorted
// (stable, ascending key) in place by a read-compare-write sequencer on the one
// RAM: each inserted record is read, then captured while its left neighbour is
// fetched, and each larger neighbour is shifted right until it is written in place.
// Records are then emitted at one beat per cycle when the output is not
// stalled, the final beat marked. The input is stalled from the last beat
// until the state register returns to load after the final record of the set
// has entered the output register.
module prefix_insertion_sorter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pis_pkg::key_t in_key,
  input  pis_pkg::tag_t in_tag,
  input  logic          in_last_item,
  output logic          out_valid,
  input  logic          out_stall,
  output pis_pkg::key_t out_key_res,
  output pis_pkg::tag_t out_tag_res,
  output logic          out_last_out,
  output logic          out_overflow
);
  import pis_pkg::*;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_IRD  = 3'd1;
  localparam logic [2:0] ST_ICAP = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_PUT  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  logic       ovf_r, ovf_nxt;
  cnt_t       len_r, len_nxt;
  cnt_t       i_r, i_nxt;
  addr_t      pos_r, pos_nxt;
  rec_t       hold_r, hold_nxt;
  cnt_t       e_r, e_nxt;
  logic       rd_pend_r, rd_pend_nxt;
  logic       pend_last_r, pend_last_nxt;
  logic       out_valid_r, out_valid_nxt;
  rec_t       out_rec_r;
  logic       out_last_r, out_ovf_r;

  logic       we, re;
  addr_t      waddr, raddr;
  rec_t       wdata, rdata;
  logic [REC_W-1:0] rdata_raw;

  logic       accept, load_out, issue, free;
  cnt_t       i_inc;

  pis_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_rec_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata  = rec_t'(rdata_raw);
  assign accept = in_valid && !in_stall;
  assign free   = !out_valid_r || !out_stall;
  assign i_inc  = i_r + cnt_t'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    len_nxt       = len_r;
    i_nxt         = i_r;
    pos_nxt       = pos_r;
    hold_nxt      = hold_r;
    e_nxt         = e_r;
    rd_pend_nxt   = rd_pend_r;
    pend_last_nxt = pend_last_r;
    we            = 1'b0;
    waddr         = count_r[AW-1:0];
    wdata         = '{key: in_key, tag: in_tag};
    re            = 1'b0;
    raddr         = i_r[AW-1:0];
    load_out      = 1'b0;
    issue         = 1'b0;
    in_stall      = (state_r != ST_LOAD);

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (count_r < cnt_t'(CAPACITY)) begin
            we        = 1'b1;
            count_nxt = count_r + cnt_t'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_item) begin
            len_nxt = count_nxt >> 1;
            i_nxt   = cnt_t'(1);
            e_nxt   = '0;
            if (cnt_t'(1) >= len_nxt) begin
              state_nxt = ST_EMIT;
            end else begin
              state_nxt = ST_IRD;
            end
          end
        end
      end
      ST_IRD: begin
        re        = 1'b1;
        raddr     = i_r[AW-1:0];
        state_nxt = ST_ICAP;
      end
      ST_ICAP: begin
        // capture the record to insert and fetch its left neighbour
        hold_nxt  = rdata;
        pos_nxt   = i_r[AW-1:0];
        re        = 1'b1;
        raddr     = i_r[AW-1:0] - addr_t'(1);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        we    = 1'b1;
        waddr = pos_r;
        if (rdata.key > hold_r.key) begin
          // shift neighbour right, fetch the next one down if any remain
          wdata   = rdata;
          pos_nxt = pos_r - addr_t'(1);
          if (pos_r == addr_t'(1)) begin
            state_nxt = ST_PUT;
          end else begin
            re    = 1'b1;
            raddr = pos_r - addr_t'(2);
          end
        end else begin
          wdata = hold_r;
          i_nxt = i_inc;
          if (i_inc >= len_r) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IRD;
          end
        end
      end
      ST_PUT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = hold_r;
        i_nxt = i_inc;
        if (i_inc >= len_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IRD;
        end
      end
      ST_EMIT: begin
        load_out = rd_pend_r && free;
        issue    = (e_r < count_r) && (!rd_pend_r || load_out);
        re       = issue;
        raddr    = e_r[AW-1:0];
        if (issue) begin
          e_nxt         = e_r + cnt_t'(1);
          pend_last_nxt = ((e_r + cnt_t'(1)) == count_r);
        end
        rd_pend_nxt = issue || (rd_pend_r && !load_out);
        if ((e_r == count_r) && !rd_pend_r) begin
          // set done: clear for the next one
          state_nxt = ST_LOAD;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    i_r         <= i_nxt;
    pos_r       <= pos_nxt;
    hold_r      <= hold_nxt;
    e_r         <= e_nxt;
    pend_last_r <= pend_last_nxt;
    if (load_out) begin
      out_rec_r  <= rdata;
      out_last_r <= pend_last_r;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_res  = out_rec_r.key;
  assign out_tag_res  = out_rec_r.tag;
  assign out_last_out = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

### tb/sv/sort_order_checker.sv
`timescale 1ns / 1ps
// Checker for the prefix insertion sorter: watches both channels, predicts the
// emitted order of each record set and compares every result beat. Needs pis_pkg.
module sort_order_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  pis_pkg::key_t in_key,
  input  pis_pkg::tag_t in_tag,
  input  logic          in_last_item,
  input  logic          out_valid,
  input  logic          out_stall,
  input  pis_pkg::key_t out_key_res,
  input  pis_pkg::tag_t out_tag_res,
  input  logic          out_last_out,
  input  logic          out_overflow,
  output int            fail_count,
  output int            due_count,
  output int            beats_seen
);

  import pis_pkg::*;

  typedef struct packed {
    key_t key;
    tag_t tag;
    logic last;
    logic ovf;
  } sorted_rec_t;

  key_t        held_key [CAPACITY];
  tag_t        held_tag [CAPACITY];
  int          held_count;
  logic        held_ovf;
  sorted_rec_t sorted_recs_q[$];
  sorted_rec_t due_rec;

  // Sort the lower half of the held set, queue the whole set in emission order
  // and clear for the next set.
  task automatic settle_set();
    key_t        k;
    tag_t        t;
    int          pos;
    int          half;
    sorted_rec_t r;
    half = held_count / 2;
    for (int i = 1; i < half; i++) begin
      k   = held_key[i];
      t   = held_tag[i];
      pos = i;
      // strict compare keeps equal keys in arrival order
      while (pos > 0 && held_key[pos-1] > k) begin
        held_key[pos] = held_key[pos-1];
        held_tag[pos] = held_tag[pos-1];
        pos--;
      end
      held_key[pos] = k;
      held_tag[pos] = t;
    end
    for (int i = 0; i < held_count; i++) begin
      r.key  = held_key[i];
      r.tag  = held_tag[i];
      r.last = (i == held_count - 1);
      r.ovf  = held_ovf;
      sorted_recs_q.push_back(r);
    end
    held_count = 0;
    held_ovf   = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      held_ovf   = 1'b0;
      sorted_recs_q.delete();
      fail_count = 0;
      beats_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (sorted_recs_q.size() == 0) begin
          $error("result beat with nothing due: key_res %h tag_res %h", out_key_res,
                 out_tag_res);
          fail_count++;
        end else begin
          due_rec = sorted_recs_q.pop_front();
          if (out_key_res !== due_rec.key) begin
            $error("key_res expected %h actual %h", due_rec.key, out_key_res);
            fail_count++;
          end
          if (out_tag_res !== due_rec.tag) begin
            $error("tag_res expected %h actual %h", due_rec.tag, out_tag_res);
            fail_count++;
          end
          if (out_last_out !== due_rec.last) begin
            $error("last_out expected %b actual %b", due_rec.last, out_last_out);
            fail_count++;
          end
          if (out_overflow !== due_rec.ovf) begin
            $error("overflow expected %b actual %b", due_rec.ovf, out_overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        // drop beats past capacity but remember the loss
        if (held_count < CAPACITY) begin
          held_key[held_count] = in_key;
          held_tag[held_count] = in_tag;
          held_count++;
        end else begin
          held_ovf = 1'b1;
        end
        if (in_last_item) settle_set();
      end
    end
    due_count = sorted_recs_q.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the prefix insertion sorter testbench: clock, reset, record sets and
// verdict. Depends on pis_pkg, prefix_insertion_sorter and sort_order_checker.
module testbench;

  import pis_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  key_t in_key;
  tag_t in_tag;
  logic in_last_item;
  logic out_valid;
  logic out_stall;
  key_t out_key_res;
  tag_t out_tag_res;
  logic out_last_out;
  logic out_overflow;

  int fails;
  int due;
  int beats;
  int records_sent;
  int sets_sent;
  bit calm;
  bit hold_req;

  prefix_insertion_sorter i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_key       (in_key),
    .in_tag       (in_tag),
    .in_last_item (in_last_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_res  (out_key_res),
    .out_tag_res  (out_tag_res),
    .out_last_out (out_last_out),
    .out_overflow (out_overflow)
  );

  sort_order_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_key       (in_key),
    .in_tag       (in_tag),
    .in_last_item (in_last_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_res  (out_key_res),
    .out_tag_res  (out_tag_res),
    .out_last_out (out_last_out),
    .out_overflow (out_overflow),
    .fail_count   (fails),
    .due_count    (due),
    .beats_seen   (beats)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_400_000;
    $display("FAIL prefix_insertion_sorter");
    $finish;
  end

  // Receiver: random stalls, periodic calm windows, one long hold-off.
  initial begin
    int  cyc;
    int  hold_left;
    bit  hold_done;
    cyc       = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (cyc % 3000 < 500) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 32);
      end
    end
  end

  // Offer one beat, with an optional gap first; hold the payload until taken.
  task automatic send_rec(input key_t k, input tag_t t, input logic lst);
    if (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_key       <= k;
    in_tag       <= t;
    in_last_item <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    records_sent++;
  endtask

  task automatic send_set(input key_t ks[$], input tag_t ts[$]);
    foreach (ks[i]) send_rec(ks[i], ts[i], i == ks.size() - 1);
    sets_sent++;
  endtask

  task automatic random_set(input int len);
    key_t ks[$];
    tag_t ts[$];
    int   flavour;
    flavour = $urandom_range(2);
    for (int i = 0; i < len; i++) begin
      case (flavour)
        0: ks.push_back(key_t'($urandom_range(0, 65535)));
        // narrow range forces plenty of equal keys
        1: ks.push_back(key_t'($urandom_range(0, 7)));
        default: begin
          case ($urandom_range(2))
            0:       ks.push_back(key_t'(0));
            1:       ks.push_back(key_t'(16'hFFFF));
            default: ks.push_back(key_t'($urandom_range(0, 65535)));
          endcase
        end
      endcase
      ts.push_back(tag_t'($urandom_range(0, 255)));
    end
    send_set(ks, ts);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (due != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    int set_no;
    int rnd_items;
    records_sent = 0;
    sets_sent    = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    in_valid     <= 1'b0;
    in_key       <= '0;
    in_tag       <= '0;
    in_last_item <= 1'b0;
    rst_n        <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // single record: nothing to sort
    send_set('{16'hFFFF}, '{8'hFF});
    // two records: sorted prefix of one
    send_set('{16'h0000, 16'hFFFF}, '{8'h00, 8'hFF});
    // odd count: the unsorted upper half stays out of order
    send_set('{16'd9, 16'd8, 16'd2}, '{8'd1, 8'd2, 8'd3});
    // mixed order with repeats and both key extremes
    send_set('{16'hFFFF, 16'd40000, 16'd40000, 16'd1, 16'd0, 16'd40000, 16'd5, 16'd3,
               16'd2},
             '{8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18});
    // equal keys interleaved: stability check
    send_set('{16'h8000, 16'h0001, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000,
               16'h0001, 16'h0000, 16'h1234},
             '{8'h80, 8'h01, 8'h81, 8'h02, 8'hFE, 8'h7F, 8'h82, 8'h03, 8'h55, 8'hAA});

    // let every directed result drain before the random part
    wait_drained();

    hold_req  = 1'b1;
    set_no    = 0;
    rnd_items = 0;
    while (rnd_items < 245) begin
      case (set_no)
        0:       len = 20;
        3:       len = CAPACITY;
        // overflow: extra beats and the last one are dropped
        6:       len = CAPACITY + 2;
        default: len = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 12);
      endcase
      calm = (set_no >= 10 && set_no < 16);
      random_set(len);
      rnd_items += len;
      set_no++;
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d record sets from %0d records, %0d result beats checked,",
             sets_sent, records_sent, beats);
    $display("including single-record, equal-key, full-capacity and overflowing sets.");
    if (fails == 0 && due == 0) begin
      $display("PASS prefix_insertion_sorter");
    end else begin
      $display("FAIL prefix_insertion_sorter");
    end
    $finish;
  end

endmodule

### prefix_insertion_sorter.f
rtl/pis_pkg.sv
rtl/pis_ram.sv
rtl/prefix_insertion_sorter.sv
tb/sv/sort_order_checker.sv
tb/sv/testbench.sv
